[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the kernel block; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked property, disabled while reset is asserted
`define QBWG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property, checked through reset as well
`define QBWG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QBWG_ASSERT(lbl, clk, rst_n, prop, msg)
`define QBWG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/qbwg_pkg.sv]
// ----------------------------------------------------------------------------
// qbwg_pkg
// Shared widths, constants, stage indexes and types of the B-spline kernel.
// ----------------------------------------------------------------------------
package qbwg_pkg;

	localparam int POS_W  = 32;
	localparam int CFG_W  = 32;
	localparam int WGT_W  = 16;
	localparam int GRAD_W = 48;
	localparam int CIDX_W = 2;

	// Reference coordinate magnitude, Q.16, saturated to 2.0
	localparam int UQ_W = 18;
	// 1D weight, unsigned Q0.32
	localparam int W1_W = 32;
	// Derivative magnitude, Q.16, at most 1.0
	localparam int G_W  = 17;

	localparam logic [UQ_W-1:0]   UQ_HALF          = 18'd32768;
	localparam logic [UQ_W-1:0]   UQ_THREE_HALVES  = 18'd98304;
	localparam logic [UQ_W-1:0]   UQ_TWO           = 18'd131072;
	localparam logic [W1_W-1:0]   W_THREE_QUARTERS = 32'd3221225472;
	localparam logic [GRAD_W-1:0] GRAD_MAX         = 48'h7FFF_FFFF_FFFF;
	localparam logic [WGT_W-1:0]  WEIGHT_MAX       = 16'd27648;

	// Pipeline stages
	localparam int NUM_STAGES = 8;
	localparam int ST_SUB     = 0;  // offset and magnitude
	localparam int ST_SCALE   = 1;  // offset times inverse spacing
	localparam int ST_ROUND   = 2;  // round and saturate u
	localparam int ST_KERN    = 3;  // 1D weight and derivative
	localparam int ST_PAIR    = 4;  // pairwise weight products
	localparam int ST_WPROD   = 5;  // full weight, derivative times pair
	localparam int ST_RSCALE  = 6;  // gradient times inverse spacing
	localparam int ST_OUT     = 7;  // sign, clamp, output register

	typedef logic [NUM_STAGES-1:0] stage_en_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_CENTER_X    = 2'd0,
		CFG_CENTER_Y    = 2'd1,
		CFG_CENTER_Z    = 2'd2,
		CFG_INV_SPACING = 2'd3
	} cfg_reg_t;

endpackage

[src/qbwg_point_if.sv]
// ----------------------------------------------------------------------------
// qbwg_point_if
// Input channel: one 3D point per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qbwg_point_if import qbwg_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

[src/qbwg_result_if.sv]
// ----------------------------------------------------------------------------
// qbwg_result_if
// Output channel: weight and gradient per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qbwg_result_if import qbwg_pkg::*; ;
	logic                     valid;
	logic                     ready;
	logic        [WGT_W-1:0]  weight;
	logic signed [GRAD_W-1:0] grad_x;
	logic signed [GRAD_W-1:0] grad_y;
	logic signed [GRAD_W-1:0] grad_z;

	modport source (output valid, output weight, output grad_x, output grad_y,
		output grad_z, input ready);
	modport sink   (input valid, input weight, input grad_x, input grad_y,
		input grad_z, output ready);
endinterface

[src/qbwg_axis.sv]
// ----------------------------------------------------------------------------
// qbwg_axis
// One axis, stages 1 to 4: offset, scale to u, round and saturate, then the
// 1D quadratic weight (Q0.32) and derivative magnitude (Q.16).
// ----------------------------------------------------------------------------
module qbwg_axis import qbwg_pkg::*; (
	input  logic                    clk,
	input  stage_en_t               en,
	input  logic signed [POS_W-1:0] pos,
	input  logic signed [POS_W-1:0] ctr,
	input  logic        [CFG_W-1:0] inv,
	output logic        [W1_W-1:0]  w_s4,
	output logic        [G_W-1:0]   g_s4,
	output logic                    neg_s4
);

	logic signed [POS_W:0]  diff;
	logic        [POS_W:0]  diff_neg;
	logic        [POS_W-1:0] mag_s1;
	logic                    neg_s1;
	logic        [63:0]      prod_s2;
	logic                    neg_s2;
	logic        [47:0]      rnd;
	logic        [UQ_W-1:0]  a_s3;
	logic                    neg_s3;
	logic        [G_W-1:0]   tail;
	logic        [32:0]      tail_sq;
	logic        [29:0]      core_sq;
	logic        [W1_W-1:0]  w_nxt;
	logic        [G_W-1:0]   g_nxt;

	// Stage 1: exact 33-bit offset and its magnitude
	always_comb begin
		diff     = {pos[POS_W-1], pos} - {ctr[POS_W-1], ctr};
		diff_neg = -diff;
	end

	always_ff @(posedge clk) begin
		if (en[ST_SUB]) begin
			neg_s1 <= diff[POS_W];
			mag_s1 <= diff[POS_W] ? diff_neg[POS_W-1:0] : diff[POS_W-1:0];
		end
	end

	// Stage 2: scale by inverse spacing, Q32.32
	always_ff @(posedge clk) begin
		if (en[ST_SCALE]) begin
			prod_s2 <= 64'(mag_s1) * 64'(inv);
			neg_s2  <= neg_s1;
		end
	end

	// Stage 3: round half away from zero to Q.16, saturate at 2.0
	assign rnd = prod_s2[63:16] + 48'(prod_s2[15]);

	always_ff @(posedge clk) begin
		if (en[ST_ROUND]) begin
			a_s3   <= (rnd > 48'(UQ_TWO)) ? UQ_TWO : rnd[UQ_W-1:0];
			neg_s3 <= neg_s2;
		end
	end

	// Stage 4: piecewise weight and derivative magnitude
	always_comb begin
		tail    = G_W'(UQ_THREE_HALVES - a_s3);
		tail_sq = 33'(tail) * 33'(tail);
		core_sq = 30'(a_s3[14:0]) * 30'(a_s3[14:0]);
		if (a_s3 >= UQ_THREE_HALVES) begin
			w_nxt = '0;
		end else if (a_s3 >= UQ_HALF) begin
			w_nxt = tail_sq[32:1];
		end else begin
			w_nxt = W_THREE_QUARTERS - W1_W'(core_sq);
		end
		if (a_s3 <= UQ_HALF) begin
			g_nxt = {a_s3[G_W-2:0], 1'b0};
		end else if (a_s3 < UQ_THREE_HALVES) begin
			g_nxt = tail;
		end else begin
			g_nxt = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_KERN]) begin
			w_s4   <= w_nxt;
			g_s4   <= g_nxt;
			neg_s4 <= neg_s3;
		end
	end

endmodule

[src/qbwg_grad.sv]
// ----------------------------------------------------------------------------
// qbwg_grad
// One gradient component, stages 6 to 8: derivative times the pair weight,
// times inverse spacing, then clamp and apply the sign opposite to u.
// ----------------------------------------------------------------------------
module qbwg_grad import qbwg_pkg::*; (
	input  logic                     clk,
	input  stage_en_t                en,
	input  logic        [G_W-1:0]    g,
	input  logic        [W1_W-1:0]   pw,
	input  logic                     neg,
	input  logic        [CFG_W-1:0]  inv,
	output logic signed [GRAD_W-1:0] grad_s8
);

	logic [48:0]       gp;
	logic [32:0]       t_s6;
	logic              neg_s6;
	logic [64:0]       rp;
	logic [33:0]       r_s7;
	logic              neg_s7;
	logic [GRAD_W-1:0] mag;

	// Stage 6: derivative times pair weight, rounded to Q.32
	assign gp = 49'(g) * 49'(pw);

	always_ff @(posedge clk) begin
		if (en[ST_WPROD]) begin
			t_s6   <= gp[48:16] + 33'(gp[15]);
			neg_s6 <= neg;
		end
	end

	// Stage 7: times inverse spacing, rounded to Q.16
	assign rp = 65'(inv) * 65'(t_s6);

	always_ff @(posedge clk) begin
		if (en[ST_RSCALE]) begin
			r_s7   <= 34'(rp[64:32]) + 34'(rp[31]);
			neg_s7 <= neg_s6;
		end
	end

	// Stage 8: clamp the magnitude, then sign it against u
	assign mag = (GRAD_W'(r_s7) > GRAD_MAX) ? GRAD_MAX : GRAD_W'(r_s7);

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			grad_s8 <= neg_s7 ? signed'(mag) : -signed'(mag);
		end
	end

endmodule

[src/quadratic_bspline_weight_gradient.sv]
// ----------------------------------------------------------------------------
// quadratic_bspline_weight_gradient: 3D quadratic B-spline weight and gradient
// Each accepted point passes 8 register stages on its way to a valid result.
// Throughput: one point per cycle unless stalled; a stalled output holds its
// stage and backpressure collapses bubbles stage by stage. Reset clears valid
// bits, centers to 0, inverse spacing to 1.0; the pipeline is usable at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadratic_bspline_weight_gradient import qbwg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_data,
	qbwg_point_if.sink        point,
	qbwg_result_if.source     result
);

	logic signed [POS_W-1:0] center_x_q;
	logic signed [POS_W-1:0] center_y_q;
	logic signed [POS_W-1:0] center_z_q;
	logic        [CFG_W-1:0] inv_spacing_q;

	stage_en_t vld_q;
	stage_en_t vld_in;
	stage_en_t en;

	logic [W1_W-1:0] wx_s4, wy_s4, wz_s4;
	logic [G_W-1:0]  gx_s4, gy_s4, gz_s4;
	logic            nx_s4, ny_s4, nz_s4;

	logic [63:0]     pxy_prod, pyz_prod, pxz_prod;
	logic [W1_W-1:0] pxy_s5, pyz_s5, pxz_s5;
	logic [W1_W-1:0] wz_s5;
	logic [G_W-1:0]  gx_s5, gy_s5, gz_s5;
	logic            nx_s5, ny_s5, nz_s5;

	logic [63:0]      wprod;
	logic [WGT_W-1:0] weight_s6, weight_s7, weight_s8;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			center_z_q    <= '0;
			inv_spacing_q <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_CENTER_X:    center_x_q    <= signed'(cfg_data);
				CFG_CENTER_Y:    center_y_q    <= signed'(cfg_data);
				CFG_CENTER_Z:    center_z_q    <= signed'(cfg_data);
				CFG_INV_SPACING: inv_spacing_q <= cfg_data;
			endcase
		end
	end

	// Stage advance: a stage moves when it is empty or the one after moves
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || result.ready;
		for (int k = NUM_STAGES-2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in = {vld_q[NUM_STAGES-2:0], point.valid};

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign point.ready = en[ST_SUB];

	// Per-axis front end, stages 1 to 4
	qbwg_axis u_axis_x (
		.clk(clk), .en(en), .pos(point.pos_x), .ctr(center_x_q), .inv(inv_spacing_q),
		.w_s4(wx_s4), .g_s4(gx_s4), .neg_s4(nx_s4)
	);

	qbwg_axis u_axis_y (
		.clk(clk), .en(en), .pos(point.pos_y), .ctr(center_y_q), .inv(inv_spacing_q),
		.w_s4(wy_s4), .g_s4(gy_s4), .neg_s4(ny_s4)
	);

	qbwg_axis u_axis_z (
		.clk(clk), .en(en), .pos(point.pos_z), .ctr(center_z_q), .inv(inv_spacing_q),
		.w_s4(wz_s4), .g_s4(gz_s4), .neg_s4(nz_s4)
	);

	// Stage 5: pairwise weight products, rounded to Q0.32
	always_comb begin
		pxy_prod = 64'(wx_s4) * 64'(wy_s4);
		pyz_prod = 64'(wy_s4) * 64'(wz_s4);
		pxz_prod = 64'(wx_s4) * 64'(wz_s4);
	end

	always_ff @(posedge clk) begin
		if (en[ST_PAIR]) begin
			pxy_s5 <= pxy_prod[63:32] + 32'(pxy_prod[31]);
			pyz_s5 <= pyz_prod[63:32] + 32'(pyz_prod[31]);
			pxz_s5 <= pxz_prod[63:32] + 32'(pxz_prod[31]);
			wz_s5  <= wz_s4;
			gx_s5  <= gx_s4;
			gy_s5  <= gy_s4;
			gz_s5  <= gz_s4;
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
			nz_s5  <= nz_s4;
		end
	end

	// Stage 6: full weight, rounded to Q0.16; hold it alongside the gradient
	assign wprod = 64'(pxy_s5) * 64'(wz_s5);

	always_ff @(posedge clk) begin
		if (en[ST_WPROD]) begin
			weight_s6 <= wprod[63:48] + 16'(wprod[47]);
		end
		if (en[ST_RSCALE]) begin
			weight_s7 <= weight_s6;
		end
		if (en[ST_OUT]) begin
			weight_s8 <= weight_s7;
		end
	end

	// Gradient components, stages 6 to 8
	qbwg_grad u_grad_x (
		.clk(clk), .en(en), .g(gx_s5), .pw(pyz_s5), .neg(nx_s5), .inv(inv_spacing_q),
		.grad_s8(result.grad_x)
	);

	qbwg_grad u_grad_y (
		.clk(clk), .en(en), .g(gy_s5), .pw(pxz_s5), .neg(ny_s5), .inv(inv_spacing_q),
		.grad_s8(result.grad_y)
	);

	qbwg_grad u_grad_z (
		.clk(clk), .en(en), .g(gz_s5), .pw(pxy_s5), .neg(nz_s5), .inv(inv_spacing_q),
		.grad_s8(result.grad_z)
	);

	assign result.valid  = vld_q[ST_OUT];
	assign result.weight = weight_s8;

	// Items in flight change only by what enters and what leaves
	`QBWG_ASSERT(a_occupancy, clk, arst_n, $past(arst_n) |-> ($countones(vld_q) == $past($countones(vld_q)) + ($past(point.valid && point.ready) ? 1 : 0) - ($past(result.valid && result.ready) ? 1 : 0)), "pipeline lost or repeated an item")
	`QBWG_ASSERT(a_accept_enters, clk, arst_n, (point.valid && point.ready) |=> vld_q[ST_SUB], "accepted item did not enter the first stage")
	`QBWG_ASSERT(a_weight_peak, clk, arst_n, result.valid |-> (result.weight <= WEIGHT_MAX), "weight above kernel peak")
	`QBWG_ASSERT(a_grad_range, clk, arst_n, result.valid |-> ((result.grad_x[47:35] == '0 || result.grad_x[47:35] == '1) && (result.grad_y[47:35] == '0 || result.grad_y[47:35] == '1) && (result.grad_z[47:35] == '0 || result.grad_z[47:35] == '1)), "gradient beyond its bound")

endmodule
